/* rtl/core/ibrs_pkg.sv */
// ----------------------------------------------------------------------------
// ibrs_pkg
// Shared types and codes for the sensor burst read sequencer.
// ----------------------------------------------------------------------------
package ibrs_pkg;

   // Number of bytes in one burst and number of axes reported
   localparam int unsigned NUM_BYTES = 14;
   localparam int unsigned NUM_AXES  = 6;

   typedef logic [3:0] byte_idx_type;
   typedef logic [2:0] axis_idx_type;

   // Operation codes of an input word
   localparam logic OP_START = 1'b0;
   localparam logic OP_EVENT = 1'b1;

   // Bus event codes
   localparam logic [2:0] EV_MODE_SELECT   = 3'd0;
   localparam logic [2:0] EV_TX_SELECTED   = 3'd1;
   localparam logic [2:0] EV_BYTE_SENT     = 3'd2;
   localparam logic [2:0] EV_RX_SELECTED   = 3'd3;
   localparam logic [2:0] EV_BYTE_RECEIVED = 3'd4;

   // Control codes for start, stop and ack requests
   localparam logic [1:0] CTRL_KEEP = 2'd0;
   localparam logic [1:0] CTRL_ON   = 2'd1;
   localparam logic [1:0] CTRL_OFF  = 2'd2;

   // Result kinds
   localparam logic KIND_CMD  = 1'b0;
   localparam logic KIND_AXIS = 1'b1;

   // Configuration register indexes
   localparam logic [1:0] CSR_SENSOR_READY   = 2'd0;
   localparam logic [1:0] CSR_DEVICE_ADDRESS = 2'd1;
   localparam logic [1:0] CSR_FIRST_REGISTER = 2'd2;
   localparam logic [1:0] CSR_NEGATE_MASK    = 2'd3;

   // Configuration reset values
   localparam logic [7:0] RST_DEVICE_ADDRESS = 8'hD0;
   localparam logic [7:0] RST_FIRST_REGISTER = 8'h3B;
   localparam logic [5:0] RST_NEGATE_MASK    = 6'd27;

   // High byte of each axis in the burst (temperature pair 6/7 skipped)
   localparam byte_idx_type AXIS_HI_BYTE [NUM_AXES] =
      '{4'd0, 4'd2, 4'd4, 4'd8, 4'd10, 4'd12};

   // One bus command result
   typedef struct packed {
      logic       send_valid;
      logic [7:0] tx_byte;
      logic [1:0] start_ctrl;
      logic [1:0] stop_ctrl;
      logic [1:0] ack_ctrl;
      logic       bus_reset;
   } cmd_type;

endpackage

/* rtl/core/imu_i2c_burst_read_sequencer_top.sv */
// ----------------------------------------------------------------------------
// imu_i2c_burst_read_sequencer_top
// Event-driven bus master sequencer for a 14-byte sensor burst read with
// axis assembly, negation and first-nonzero offset capture.
// ----------------------------------------------------------------------------
//  channel | direction | handshake               | payload
//  req_    | in        | req_valid / req_stall   | operation, event_code, rx_byte
//  rsp_    | out       | rsp_valid / rsp_stall   | command or axis fields, last
//  csr_    | in        | csr_write_enable        | csr_index, csr_data
//
//  An accepted word is held in the input register, then its result loads
//  the output register; a word with one or no result frees the input
//  register as it advances, so one word per cycle is sustained while rsp_stall is low.
//  The final byte of a burst yields six axis words from the output register,
//  one per cycle while rsp_stall is low, so the word behind it waits in the
//  input register until the last axis word leaves.
//  Synchronous active-high reset clears control state and offsets.
//  rsp_stall holds the output register; req_stall rises only when the input
//  register holds a word the output register cannot yet take.
// ----------------------------------------------------------------------------
module imu_i2c_burst_read_sequencer_top (
   input  logic               clock,
   input  logic               reset,
   // input channel
   input  logic               req_valid,
   output logic               req_stall,
   input  logic               req_operation,
   input  logic [2:0]         req_event_code,
   input  logic [7:0]         req_rx_byte,
   // result channel
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic               rsp_kind,
   output logic               rsp_send_valid,
   output logic [7:0]         rsp_tx_byte,
   output logic [1:0]         rsp_start_ctrl,
   output logic [1:0]         rsp_stop_ctrl,
   output logic [1:0]         rsp_ack_ctrl,
   output logic               rsp_bus_reset,
   output logic [2:0]         rsp_axis_index,
   output logic signed [15:0] rsp_axis_value,
   output logic signed [15:0] rsp_axis_offset,
   output logic               rsp_last,
   // configuration
   input  logic               csr_write_enable,
   input  logic [1:0]         csr_index,
   input  logic [7:0]         csr_data
);
   import ibrs_pkg::*;

   // Sequence step codes
   localparam logic [4:0] STEP_IDLE       = 5'd1;
   localparam logic [4:0] STEP_TX_POINTER = 5'd2;
   localparam logic [4:0] STEP_RESTART    = 5'd3;
   localparam logic [4:0] STEP_TX_READ    = 5'd4;
   localparam logic [4:0] STEP_ACK_ON     = 5'd5;
   localparam logic [4:0] STEP_FIRST_BYTE = 5'd6;
   localparam logic [4:0] STEP_PRE_LAST   = 5'd18;
   localparam logic [4:0] STEP_LAST_BYTE  = 5'd19;
   localparam axis_idx_type LAST_AXIS     = axis_idx_type'(NUM_AXES - 1);

   // Configuration registers
   logic       ready_ff;
   logic [7:0] dev_addr_ff;
   logic [7:0] first_reg_ff;
   logic [5:0] neg_mask_ff;

   // Input register
   logic       s1_valid_ff;
   logic       s1_op_ff;
   logic [2:0] s1_ev_ff;
   logic [7:0] s1_rx_ff;

   // Sequencer state
   logic [4:0]  step_ff, step_in;
   logic        busy_ff, busy_in;
   logic [7:0]  byte_ff [NUM_BYTES];
   logic [15:0] off_ff  [NUM_AXES];

   // Output register
   logic         rsp_valid_ff;
   logic         burst_ff;
   axis_idx_type cnt_ff;
   cmd_type      cmd_ff;
   logic [15:0]  axis_val_ff [NUM_AXES];

   // Processing results
   logic         has_cmd;
   logic         do_burst;
   logic         store_we;
   cmd_type      cmd_in;
   byte_idx_type store_idx;
   logic [15:0]  axis_word [NUM_AXES];
   logic [15:0]  axis_in   [NUM_AXES];
   logic [15:0]  off_in    [NUM_AXES];

   logic out_free;
   logic s1_advance;
   logic req_take;

   // Handshake
   assign out_free   = !rsp_valid_ff ||
                       (!rsp_stall && (!burst_ff || cnt_ff == LAST_AXIS));
   assign s1_advance = s1_valid_ff && out_free;
   assign req_stall  = s1_valid_ff && !out_free;
   assign req_take   = req_valid && !req_stall;
   assign store_idx  = byte_idx_type'(step_ff - STEP_FIRST_BYTE);

   // Configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         ready_ff     <= 1'b0;
         dev_addr_ff  <= RST_DEVICE_ADDRESS;
         first_reg_ff <= RST_FIRST_REGISTER;
         neg_mask_ff  <= RST_NEGATE_MASK;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_SENSOR_READY:   ready_ff     <= csr_data[0];
            CSR_DEVICE_ADDRESS: dev_addr_ff  <= csr_data;
            CSR_FIRST_REGISTER: first_reg_ff <= csr_data;
            CSR_NEGATE_MASK:    neg_mask_ff  <= csr_data[5:0];
            default: ;
         endcase
      end
   end

   // Input register
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_take) begin
         s1_valid_ff <= 1'b1;
      end else if (s1_advance) begin
         s1_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_op_ff <= req_operation;
         s1_ev_ff <= req_event_code;
         s1_rx_ff <= req_rx_byte;
      end
   end

   // Step sequencer
   always_comb begin
      cmd_in   = '0;
      has_cmd  = 1'b0;
      do_burst = 1'b0;
      store_we = 1'b0;
      step_in  = step_ff;
      busy_in  = busy_ff;
      if (s1_op_ff == OP_START) begin
         if (ready_ff) begin
            has_cmd           = 1'b1;
            cmd_in.start_ctrl = CTRL_ON;
            cmd_in.bus_reset  = busy_ff;
            busy_in           = 1'b1;
         end
      end else begin
         case (step_ff)
            STEP_IDLE: begin
               if (s1_ev_ff == EV_MODE_SELECT) begin
                  has_cmd           = 1'b1;
                  cmd_in.send_valid = 1'b1;
                  cmd_in.tx_byte    = dev_addr_ff;
                  cmd_in.start_ctrl = CTRL_OFF;
                  cmd_in.stop_ctrl  = CTRL_OFF;
                  step_in           = STEP_TX_POINTER;
               end
            end
            STEP_TX_POINTER: begin
               if (s1_ev_ff == EV_TX_SELECTED) begin
                  has_cmd           = 1'b1;
                  cmd_in.send_valid = 1'b1;
                  cmd_in.tx_byte    = first_reg_ff;
                  step_in           = STEP_RESTART;
               end
            end
            STEP_RESTART: begin
               if (s1_ev_ff == EV_BYTE_SENT) begin
                  has_cmd           = 1'b1;
                  cmd_in.start_ctrl = CTRL_ON;
                  step_in           = STEP_TX_READ;
               end
            end
            STEP_TX_READ: begin
               if (s1_ev_ff == EV_MODE_SELECT) begin
                  has_cmd           = 1'b1;
                  cmd_in.send_valid = 1'b1;
                  cmd_in.tx_byte    = dev_addr_ff | 8'h01;
                  step_in           = STEP_ACK_ON;
               end
            end
            STEP_ACK_ON: begin
               if (s1_ev_ff == EV_RX_SELECTED) begin
                  has_cmd         = 1'b1;
                  cmd_in.ack_ctrl = CTRL_ON;
                  step_in         = STEP_FIRST_BYTE;
               end
            end
            default: begin
               if (step_ff inside {[STEP_FIRST_BYTE:STEP_LAST_BYTE]}) begin
                  if (s1_ev_ff == EV_BYTE_RECEIVED) begin
                     store_we = 1'b1;
                     if (step_ff == STEP_LAST_BYTE) begin
                        // burst complete: report axes and go idle
                        do_burst = 1'b1;
                        step_in  = STEP_IDLE;
                        busy_in  = 1'b0;
                     end else begin
                        step_in = step_ff + 5'd1;
                        if (step_ff == STEP_PRE_LAST) begin
                           // drop ACK and ask for STOP before the last byte
                           has_cmd          = 1'b1;
                           cmd_in.stop_ctrl = CTRL_ON;
                           cmd_in.ack_ctrl  = CTRL_OFF;
                        end
                     end
                  end
               end else begin
                  step_in = STEP_IDLE;
               end
            end
         endcase
         // an unexpected mode select restarts the sequence
         if (step_in == step_ff && s1_ev_ff == EV_MODE_SELECT) begin
            step_in = STEP_IDLE;
         end
      end
   end

   // Axis assembly; the final low byte comes straight from the input word
   always_comb begin
      for (int i = 0; i < NUM_AXES; i++) begin
         if (i == NUM_AXES - 1) begin
            axis_word[i] = {byte_ff[AXIS_HI_BYTE[i]], s1_rx_ff};
         end else begin
            axis_word[i] = {byte_ff[AXIS_HI_BYTE[i]],
                            byte_ff[byte_idx_type'(AXIS_HI_BYTE[i] + 4'd1)]};
         end
         axis_in[i] = neg_mask_ff[i] ? 16'(16'd0 - axis_word[i]) : axis_word[i];
         off_in[i]  = (off_ff[i] == 16'd0) ? axis_in[i] : off_ff[i];
      end
   end

   // Sequencer state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= STEP_IDLE;
         busy_ff <= 1'b0;
      end else if (s1_advance) begin
         step_ff <= step_in;
         busy_ff <= busy_in;
      end
   end

   // Byte store, written in burst order
   always_ff @(posedge clock) begin
      if (s1_advance && store_we) begin
         byte_ff[store_idx] <= s1_rx_ff;
      end
   end

   // Offsets latch the first nonzero reading
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_AXES; i++) begin
            off_ff[i] <= 16'd0;
         end
      end else if (s1_advance && do_burst) begin
         for (int i = 0; i < NUM_AXES; i++) begin
            off_ff[i] <= off_in[i];
         end
      end
   end

   // Output register and axis burst counter
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         burst_ff     <= 1'b0;
         cnt_ff       <= '0;
      end else if (out_free) begin
         rsp_valid_ff <= s1_advance && (has_cmd || do_burst);
         burst_ff     <= s1_advance && do_burst;
         cnt_ff       <= '0;
      end else if (rsp_valid_ff && !rsp_stall) begin
         cnt_ff <= cnt_ff + 3'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (out_free && s1_advance) begin
         cmd_ff <= cmd_in;
         if (do_burst) begin
            for (int i = 0; i < NUM_AXES; i++) begin
               axis_val_ff[i] <= axis_in[i];
            end
         end
      end
   end

   // Result fields
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_kind        = burst_ff ? KIND_AXIS : KIND_CMD;
   assign rsp_send_valid  = burst_ff ? 1'b0 : cmd_ff.send_valid;
   assign rsp_tx_byte     = burst_ff ? 8'd0 : cmd_ff.tx_byte;
   assign rsp_start_ctrl  = burst_ff ? CTRL_KEEP : cmd_ff.start_ctrl;
   assign rsp_stop_ctrl   = burst_ff ? CTRL_KEEP : cmd_ff.stop_ctrl;
   assign rsp_ack_ctrl    = burst_ff ? CTRL_KEEP : cmd_ff.ack_ctrl;
   assign rsp_bus_reset   = burst_ff ? 1'b0 : cmd_ff.bus_reset;
   assign rsp_axis_index  = burst_ff ? cnt_ff : 3'd0;
   assign rsp_axis_value  = burst_ff ? signed'(axis_val_ff[cnt_ff]) : 16'sd0;
   assign rsp_axis_offset = burst_ff ? signed'(off_ff[cnt_ff]) : 16'sd0;
   assign rsp_last        = !burst_ff || cnt_ff == LAST_AXIS;

   // Checks
   a_step_range: assert property (@(posedge clock) disable iff (reset)
      step_ff >= STEP_IDLE && step_ff <= STEP_LAST_BYTE)
      else $error("step left its range");

   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && burst_ff |-> cnt_ff <= LAST_AXIS)
      else $error("axis counter overran");

   a_burst_done: assert property (@(posedge clock) disable iff (reset)
      s1_advance && do_burst |=> !busy_ff && step_ff == STEP_IDLE && burst_ff)
      else $error("burst completion did not return to idle");

   a_no_idle_stall: assert property (@(posedge clock) disable iff (reset)
      !s1_valid_ff |-> !req_stall)
      else $error("stall raised with empty input register");

endmodule
